// File: hw/rtl/ordered_array_list_engine_defines.svh
// Assertion macros used by the ordered array list engine sequencer (oale_ctrl).
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define OALE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define OALE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/oale_pkg.sv
// Shared constants, codes and types for the ordered array list engine.
package oale_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // request kinds
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_DUMP   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_DUMP   = 4'b1000
   } state_type;

   // one memory access per cycle: a write and/or a read
   typedef struct packed {
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
   } ram_req_type;

   // result word from the sequencer
   typedef struct packed {
      logic                     valid;
      logic [1:0]               status;
      logic signed [DATA_W-1:0] data_value;
      logic [CNT_W-1:0]         entry_count;
      logic                     last;
   } rsp_type;

endpackage

// File: hw/rtl/oale_ram.sv
// Entry store: single-port-write, single-port-read memory, registered read data.
module oale_ram (
   input  logic                              clock,
   input  oale_pkg::ram_req_type             ram_req,
   output logic signed [oale_pkg::DATA_W-1:0] rd_data
);
   import oale_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data <= mem[ram_req.rd_addr];
      end
   end

endmodule

// File: hw/rtl/oale_ctrl.sv
// Sequencer: insert, search-and-shift remove and dump over the entry store.
`include "ordered_array_list_engine_defines.svh"

module oale_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [1:0]                         req_type,
   input  logic signed [oale_pkg::DATA_W-1:0] req_value,
   output logic                               busy,
   output oale_pkg::ram_req_type              ram_req,
   input  logic signed [oale_pkg::DATA_W-1:0] rd_data,
   output oale_pkg::rsp_type                  rsp
);
   import oale_pkg::*;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]        rd_idx_ff, rd_idx_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]        last_idx;
   logic                     more;

   assign busy     = (state_ff != S_IDLE);
   assign last_idx = ADDR_W'(count_ff - CNT_W'(1));
   assign more     = (rd_ptr_ff < count_ff);

   // next-state and datapath control
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      val_in    = val_ff;
      ram_req   = '0;
      rsp       = '0;

      // streaming reads while a scan is running
      if (state_ff != S_IDLE && more) begin
         ram_req.rd_en   = 1'b1;
         ram_req.rd_addr = rd_ptr_ff[ADDR_W-1:0];
         rd_ptr_in       = rd_ptr_ff + CNT_W'(1);
         rd_vld_in       = 1'b1;
         rd_idx_in       = rd_ptr_ff[ADDR_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            rd_ptr_in = '0;
            if (start) begin
               val_in = req_value;
               unique case (req_type)
                  REQ_INSERT: begin
                     rsp.valid      = 1'b1;
                     rsp.data_value = req_value;
                     rsp.last       = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp.status      = ST_FULL;
                        rsp.entry_count = count_ff;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = count_ff[ADDR_W-1:0];
                        ram_req.wr_data = req_value;
                        count_in        = count_ff + CNT_W'(1);
                        rsp.status      = ST_OK;
                        rsp.entry_count = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp.valid       = 1'b1;
                        rsp.status      = ST_EMPTY;
                        rsp.data_value  = req_value;
                        rsp.entry_count = count_ff;
                        rsp.last        = 1'b1;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  REQ_DUMP: begin
                     if (count_ff == '0) begin
                        rsp.valid  = 1'b1;
                        rsp.status = ST_EMPTY;
                        rsp.last   = 1'b1;
                     end else begin
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     // unused kind: dropped
                  end
               endcase
            end
         end

         // compare each entry as it returns from the store
         S_SEARCH: begin
            if (rd_vld_ff) begin
               if (rd_data == val_ff) begin
                  state_in = S_SHIFT;
               end else if (rd_idx_ff == last_idx) begin
                  rsp.valid       = 1'b1;
                  rsp.status      = ST_NOTFOUND;
                  rsp.data_value  = val_ff;
                  rsp.entry_count = count_ff;
                  rsp.last        = 1'b1;
                  state_in        = S_IDLE;
                  rd_vld_in       = 1'b0;
               end
            end
         end

         // move every later entry down one place
         S_SHIFT: begin
            if (rd_vld_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = rd_idx_ff - ADDR_W'(1);
               ram_req.wr_data = rd_data;
            end else if (!more) begin
               count_in        = count_ff - CNT_W'(1);
               rsp.valid       = 1'b1;
               rsp.status      = ST_OK;
               rsp.data_value  = val_ff;
               rsp.entry_count = count_ff - CNT_W'(1);
               rsp.last        = 1'b1;
               state_in        = S_IDLE;
               rd_vld_in       = 1'b0;
            end
         end

         // one result per entry
         S_DUMP: begin
            if (rd_vld_ff) begin
               rsp.valid       = 1'b1;
               rsp.status      = ST_OK;
               rsp.data_value  = rd_data;
               rsp.entry_count = count_ff;
               rsp.last        = (rd_idx_ff == last_idx);
               if (rd_idx_ff == last_idx) begin
                  state_in  = S_IDLE;
                  rd_vld_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      val_ff    <= val_in;
   end

   `OALE_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `OALE_ASSERT_IMP(a_dump_no_write, clock, reset, state_ff == S_DUMP, !ram_req.wr_en, "write during dump")
   `OALE_ASSERT_IMP(a_shift_addr, clock, reset, ram_req.wr_en && state_ff == S_SHIFT, {1'b0, ram_req.wr_addr} < count_ff, "shift write beyond list")
   `OALE_ASSERT_NXT(a_insert_count, clock, reset, state_ff == S_IDLE && start && req_type == REQ_INSERT && count_ff != CNT_W'(DEPTH), count_ff == CNT_W'($past(count_ff) + CNT_W'(1)), "insert did not grow list")

endmodule

// File: hw/rtl/ordered_array_list_engine.sv
// Top level of the ordered array list engine: sequencer, entry store, result register.
//
// Keeps an ordered list of up to DEPTH signed 32-bit words in a single-read,
// single-write memory. A request is taken when start is high and busy is low;
// each result word appears on the rsp_ ports for one cycle with rsp_valid high,
// in the cycle after the sequencer produces it, and cannot be held off. An insert,
// and any request that fails at once (full, empty), leaves busy low, so a new
// request may follow in the next cycle. A remove holds busy while the memory
// read port scans one entry per cycle, first comparing, then copying each later
// entry one place down. A dump holds busy while it gives one result word per
// entry per cycle, last flagged.
module ordered_array_list_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_type,
   input  logic signed [oale_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic signed [oale_pkg::DATA_W-1:0] rsp_data_value,
   output logic [oale_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic                               rsp_last
);
   import oale_pkg::*;

   ram_req_type              ram_req;
   logic signed [DATA_W-1:0] rd_data;
   rsp_type                  rsp;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic                     rsp_last_ff;

   oale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .req_value (req_value),
      .busy      (busy),
      .ram_req   (ram_req),
      .rd_data   (rd_data),
      .rsp       (rsp)
   );

   oale_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp.valid;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp.status;
      rsp_data_ff   <= rsp.data_value;
      rsp_count_ff  <= rsp.entry_count;
      rsp_last_ff   <= rsp.last;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_value  = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
